>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RGB fade sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/rgbfs_pkg.sv
// ----------------------------------------------------------------------------
// RGB fade sequencer package
// Shared types, constants and the per-phase move table.
// ----------------------------------------------------------------------------
package rgbfs_pkg;

    localparam logic [4:0] LAST_PHASE     = 5'd19;
    localparam logic [7:0] LEVEL_MAX      = 8'd255;
    localparam logic [7:0] LEVEL_MIN      = 8'd0;
    localparam logic [7:0] INTERVAL_RESET = 8'd20;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } channel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_t;

    // one move: nudge a channel by one toward 255 (up) or 0
    typedef struct packed {
        logic     valid;
        channel_t chan;
        logic     up;
    } move_t;

    // moves of one phase, index 0 has highest priority
    typedef struct packed {
        move_t [2:0] moves;
    } rule_t;

    // state handed to the step logic and returned by it
    typedef struct packed {
        colour_t    colour;
        logic [4:0] phase;
    } fade_state_t;

    function automatic move_t mv(input channel_t chan, input logic up);
        move_t m;
        m.valid = 1'b1;
        m.chan  = chan;
        m.up    = up;
        return m;
    endfunction

    function automatic rule_t phase_rule(input logic [4:0] phase);
        rule_t r;
        move_t none;
        none = '0;
        r.moves = {none, none, none};
        unique case (phase)
            5'd0:  r.moves[0] = mv(CH_GREEN, 1'b1);
            5'd1:  r.moves[0] = mv(CH_RED,   1'b0);
            5'd2:  r.moves[0] = mv(CH_BLUE,  1'b1);
            5'd3:  r.moves[0] = mv(CH_GREEN, 1'b0);
            5'd4:  r.moves[0] = mv(CH_RED,   1'b1);
            5'd5:  r.moves[0] = mv(CH_BLUE,  1'b0);
            5'd6:
            begin
                r.moves[0] = mv(CH_GREEN, 1'b1);
                r.moves[1] = mv(CH_BLUE,  1'b1);
            end
            5'd7:
            begin
                r.moves[0] = mv(CH_RED,  1'b0);
                r.moves[1] = mv(CH_BLUE, 1'b0);
            end
            5'd8:
            begin
                r.moves[0] = mv(CH_RED,  1'b1);
                r.moves[1] = mv(CH_BLUE, 1'b0);
            end
            5'd9:  r.moves[0] = mv(CH_GREEN, 1'b1);
            5'd10:
            begin
                r.moves[0] = mv(CH_RED,   1'b1);
                r.moves[1] = mv(CH_GREEN, 1'b0);
            end
            5'd11:
            begin
                r.moves[0] = mv(CH_GREEN, 1'b1);
                r.moves[1] = mv(CH_BLUE,  1'b0);
            end
            5'd12: r.moves[0] = mv(CH_RED,  1'b0);
            5'd13: r.moves[0] = mv(CH_BLUE, 1'b1);
            5'd14:
            begin
                r.moves[0] = mv(CH_GREEN, 1'b0);
                r.moves[1] = mv(CH_RED,   1'b1);
            end
            5'd15: r.moves[0] = mv(CH_RED,   1'b0);
            5'd16: r.moves[0] = mv(CH_GREEN, 1'b1);
            5'd17: r.moves[0] = mv(CH_BLUE,  1'b1);
            5'd18: r.moves[0] = mv(CH_GREEN, 1'b0);
            5'd19:
            begin
                r.moves[0] = mv(CH_RED,   1'b1);
                r.moves[1] = mv(CH_GREEN, 1'b1);
                r.moves[2] = mv(CH_BLUE,  1'b1);
            end
            default: r.moves = {none, none, none};
        endcase
        return r;
    endfunction

    function automatic logic [7:0] get_level(input colour_t c, input channel_t chan);
        logic [7:0] lvl;
        unique case (chan)
            CH_RED:   lvl = c.red;
            CH_GREEN: lvl = c.green;
            default:  lvl = c.blue;
        endcase
        return lvl;
    endfunction

    function automatic colour_t set_level(input colour_t c, input channel_t chan,
                                          input logic [7:0] lvl);
        colour_t r;
        r = c;
        unique case (chan)
            CH_RED:   r.red   = lvl;
            CH_GREEN: r.green = lvl;
            default:  r.blue  = lvl;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/rgbfs_step.sv
// ----------------------------------------------------------------------------
// RGB fade step
// One colour step: first movable channel of the phase rule moves by one,
// otherwise the phase advances (last phase wraps to the first, out-of-range phases reset).
// ----------------------------------------------------------------------------
module rgbfs_step
    import rgbfs_pkg::*;
(
    input  fade_state_t cur,
    output fade_state_t nxt
);

    rule_t      rule;
    logic       moved;
    logic [7:0] lvl;

    assign rule = phase_rule(cur.phase);

    // walk the three moves in priority order
    always_comb
    begin
        nxt   = cur;
        moved = 1'b0;
        lvl   = '0;
        if (cur.phase > LAST_PHASE)
        begin
            // unreachable phase: colour held, phase back to start
            nxt.phase = '0;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                lvl = get_level(cur.colour, rule.moves[k].chan);
                if (!moved && rule.moves[k].valid)
                begin
                    if (rule.moves[k].up && (lvl != LEVEL_MAX))
                    begin
                        nxt.colour = set_level(cur.colour, rule.moves[k].chan,
                                               lvl + 8'd1);
                        moved = 1'b1;
                    end
                    else if (!rule.moves[k].up && (lvl != LEVEL_MIN))
                    begin
                        nxt.colour = set_level(cur.colour, rule.moves[k].chan,
                                               lvl - 8'd1);
                        moved = 1'b1;
                    end
                end
            end
            if (!moved)
            begin
                nxt.phase = (cur.phase == LAST_PHASE) ? 5'd0 : cur.phase + 5'd1;
            end
        end
    end

endmodule

>>> rtl/rgb_fade_sequencer_core.sv
// ----------------------------------------------------------------------------
// RGB fade sequencer core
// Tick-driven colour fade through twenty phases, with start-colour loads.
// ----------------------------------------------------------------------------
//  channel | signals                                     | dir
//  --------+---------------------------------------------+-----
//  in      | in_valid, in_stall, operation, start_*      | in
//  out     | out_valid, out_stall, led_*, fade_phase     | out
//  cfg     | cfg_we, cfg_wdata (step interval)           | in
//
//  Two register stages: input register, then the step logic feeding the
//  state and result registers. One item per cycle while the output is not
//  stalled. A tick below the interval yields no result.
//  Reset clears colour, phase and divider; the interval resets to 20.
//  Output stall holds the result register and, with a full input register, the input side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_fade_sequencer_core
    import rgbfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [7:0] start_red,
    input  logic [7:0] start_green,
    input  logic [7:0] start_blue,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] led_red,
    output logic [7:0] led_green,
    output logic [7:0] led_blue,
    output logic [4:0] fade_phase,
    // configuration
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    logic        s1_valid_reg, s1_valid_next;
    op_t         s1_op_reg;
    colour_t     s1_colour_reg;

    fade_state_t state_reg, state_next;
    logic [7:0]  divider_reg, divider_next;
    logic [7:0]  interval_reg;

    logic        out_valid_reg, out_valid_next;
    fade_state_t out_reg, out_next;

    fade_state_t step_res;
    logic        s1_go;
    logic        in_take;
    logic        load_go;
    logic [8:0]  div_inc;

    // handshake control
    assign s1_go    = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;
    assign load_go  = s1_valid_reg && s1_go && (s1_op_reg == OP_LOAD);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            interval_reg <= INTERVAL_RESET;
        else if (cfg_we)
            interval_reg <= cfg_wdata;
    end

    // input register
    assign s1_valid_next = in_stall ? s1_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg     <= op_t'(operation);
            s1_colour_reg <= '{red: start_red, green: start_green, blue: start_blue};
        end
    end

    // colour step
    rgbfs_step u_step (
        .cur (state_reg),
        .nxt (step_res)
    );

    assign div_inc = {1'b0, divider_reg} + 9'd1;

    // state and result update
    always_comb
    begin
        state_next     = state_reg;
        divider_next   = divider_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = 1'b0;
            if (s1_valid_reg)
            begin
                if (s1_op_reg == OP_LOAD)
                begin
                    state_next.colour = s1_colour_reg;
                    state_next.phase  = '0;
                    out_next          = state_next;
                    out_valid_next    = 1'b1;
                end
                else if (div_inc >= {1'b0, interval_reg})
                begin
                    divider_next   = '0;
                    state_next     = step_res;
                    out_next       = step_res;
                    out_valid_next = 1'b1;
                end
                else
                begin
                    divider_next = div_inc[7:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            divider_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            divider_reg   <= divider_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // output ports
    assign out_valid  = out_valid_reg;
    assign led_red    = out_reg.colour.red;
    assign led_green  = out_reg.colour.green;
    assign led_blue   = out_reg.colour.blue;
    assign fade_phase = out_reg.phase;

    // checks
    `ASSERT_ALWAYS(a_phase_range, clk, rst_n, state_reg.phase <= LAST_PHASE)
    `ASSERT_ALWAYS(a_stall_cause, clk, rst_n, !in_stall || (out_valid_reg && out_stall))
    `ASSERT_NEXT(a_load_result, clk, rst_n, load_go, out_valid_reg && (out_reg.phase == 5'd0))

endmodule
